@@ rtl/core/atmt_pkg.sv @@
// ----------------------------------------------------------------------------
// atmt_pkg
// Shared types, constants and helpers for the access tag match table.
// ----------------------------------------------------------------------------
package atmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int UID_MAX_BYTES   = 10;
    localparam int COUNT_OUT_W     = 5;

    // Operation codes
    localparam logic [2:0] KIND_CHECK   = 3'd0;
    localparam logic [2:0] KIND_ADD     = 3'd1;
    localparam logic [2:0] KIND_REMOVE  = 3'd2;
    localparam logic [2:0] KIND_CHG_UID = 3'd3;
    localparam logic [2:0] KIND_CHG_LVL = 3'd4;

    typedef struct packed {
        logic [63:0] lo;
        logic [15:0] hi;
        logic [3:0]  len;
    } t_uid;

    typedef struct packed {
        t_uid       uid;
        logic [7:0] level;
    } t_entry;

    typedef struct packed {
        logic [2:0] kind;
        t_uid       key;
        t_uid       new_key;
        logic [7:0] level;
    } t_op;

    // Sequencing strobes from the top level to every cell
    typedef struct packed {
        logic match_en;
        logic apply_en;
    } t_ctl;

    // Hit information rippled along the cell row
    typedef struct packed {
        logic uid_seen;
        logic full_seen;
    } t_chain;

    // Saturate the length and clear the bytes at and above it
    function automatic t_uid mask_uid(input logic [63:0] lo, input logic [15:0] hi,
                                      input logic [3:0] len_raw);
        t_uid        res;
        logic [3:0]  len;
        logic [79:0] bytes;
        len   = (len_raw > 4'(UID_MAX_BYTES)) ? 4'(UID_MAX_BYTES) : len_raw;
        bytes = {hi, lo};
        for (int b = 0; b < UID_MAX_BYTES; b++) begin
            if (4'(b) >= len) begin
                bytes[8*b +: 8] = 8'h00;
            end
        end
        res.lo  = bytes[63:0];
        res.hi  = bytes[79:64];
        res.len = len;
        return res;
    endfunction

endpackage

@@ rtl/core/atmt_req_if.sv @@
// ----------------------------------------------------------------------------
// atmt_req_if
// Request channel: one table operation per beat.
// ----------------------------------------------------------------------------
interface atmt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] key_low;
    logic [15:0] key_high;
    logic [3:0]  key_len;
    logic [63:0] new_key_low;
    logic [15:0] new_key_high;
    logic [3:0]  new_key_len;
    logic [7:0]  level;

    modport source (
        output valid, kind, key_low, key_high, key_len,
               new_key_low, new_key_high, new_key_len, level,
        input  ready
    );
    modport sink (
        input  valid, kind, key_low, key_high, key_len,
               new_key_low, new_key_high, new_key_len, level,
        output ready
    );
endinterface

@@ rtl/core/atmt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// atmt_rsp_if
// Response channel: success flag and entry count, one beat per operation.
// ----------------------------------------------------------------------------
interface atmt_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [4:0] entry_count;

    modport source (output valid, ok, entry_count, input ready);
    modport sink   (input valid, ok, entry_count, output ready);
endinterface

@@ rtl/core/atmt_cell.sv @@
// ----------------------------------------------------------------------------
// atmt_cell
// One table entry: stores a UID and level, compares against the broadcast
// key and takes its upper neighbor's entry when the table compacts.
// ----------------------------------------------------------------------------
module atmt_cell
    import atmt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  t_ctl             i_ctl,
    input  t_op              i_op,
    input  logic [CNT_W-1:0] i_count,
    input  t_entry           i_next,
    input  t_chain           i_chain,
    output t_entry           o_entry,
    output t_chain           o_chain
);

    localparam logic [CNT_W:0] IDX_C  = (CNT_W+1)'(IDX);
    localparam logic [CNT_W:0] IDX_P1 = (CNT_W+1)'(IDX + 1);

    t_entry r_entry;
    logic   r_uid_hit;
    logic   r_lvl_hit;

    logic   w_valid;
    logic   w_first;
    logic   w_shift;
    logic   w_tail;

    // Decode position against the fill count and the hit ripple
    always_comb begin
        w_valid = IDX_C < {1'b0, i_count};
        w_tail  = IDX_C == {1'b0, i_count};
        w_first = r_uid_hit && !i_chain.uid_seen;
        w_shift = (r_uid_hit || i_chain.uid_seen) && (IDX_P1 < {1'b0, i_count});
        o_chain.uid_seen  = i_chain.uid_seen || r_uid_hit;
        o_chain.full_seen = i_chain.full_seen || (r_uid_hit && r_lvl_hit);
        o_entry = r_entry;
    end

    // Register compare results, then apply the update
    always_ff @(posedge i_clk) begin
        if (i_ctl.match_en) begin
            r_uid_hit <= w_valid && (r_entry.uid == i_op.key);
            r_lvl_hit <= r_entry.level == i_op.level;
        end
        if (i_ctl.apply_en) begin
            case (i_op.kind)
                KIND_ADD: begin
                    if (w_tail) begin
                        r_entry.uid   <= i_op.key;
                        r_entry.level <= i_op.level;
                    end
                end
                KIND_REMOVE: begin
                    if (w_shift) begin
                        r_entry <= i_next;
                    end
                end
                KIND_CHG_UID: begin
                    if (w_first) begin
                        r_entry.uid <= i_op.new_key;
                    end
                end
                KIND_CHG_LVL: begin
                    if (w_first) begin
                        r_entry.level <= i_op.level;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/access_tag_match_table.sv @@
// ----------------------------------------------------------------------------
// access_tag_match_table
// Table of authorized tag UIDs with access levels, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per beat (check, add, remove, change uid,
//   change level) with the key UID, replacement UID and level. o_rsp returns
//   one beat per operation: the success flag and the entry count afterwards.
//   For each operation the request beat is registered, every cell registers
//   its compare result in the next cycle, and then the cells update in place
//   (remove shifts later entries down one cell) while the response is loaded
//   into the output register. No new request is taken until the previous
//   update is done, so operations do not overlap in the cell row. The
//   first-match ripple runs across all cells.
//   Reset empties the table (count cleared) and drops any pending response.
//   While the receiver stalls, the response holds in the output register and
//   a finished update waits in the update step without touching the table.
// ----------------------------------------------------------------------------
module access_tag_match_table
    import atmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atmt_req_if.sink   i_req,
    atmt_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             r_ok;
    logic             n_ok;
    logic [CNT_W-1:0] r_out_count;

    t_ctl             w_ctl;
    logic             w_accept;
    logic             w_apply;
    logic [CNT_W+COUNT_OUT_W-1:0] w_cnt_ext;

    t_entry           w_ent   [TABLE_DEPTH+1];
    t_chain           w_chain [TABLE_DEPTH+1];

    // Handshake and sequencing strobes
    always_comb begin
        i_req.ready     = r_state == S_IDLE;
        w_accept        = i_req.valid && (r_state == S_IDLE);
        w_apply         = (r_state == S_APPLY) && (!r_out_valid || o_rsp.ready);
        w_ctl.match_en  = r_state == S_MATCH;
        w_ctl.apply_en  = w_apply;
    end

    // Cell row; the top cell sees an empty neighbor
    assign w_ent[TABLE_DEPTH] = '0;
    assign w_chain[0]         = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        atmt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_op    (r_op),
            .i_count (r_count),
            .i_next  (w_ent[g+1]),
            .i_chain (w_chain[g]),
            .o_entry (w_ent[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // Result and next count from the fill count and the far end of the ripple
    always_comb begin
        n_ok    = 1'b0;
        n_count = r_count;
        case (r_op.kind)
            KIND_CHECK: begin
                n_ok = w_chain[TABLE_DEPTH].full_seen;
            end
            KIND_ADD: begin
                if (r_count < CNT_W'(TABLE_DEPTH)) begin
                    n_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_chain[TABLE_DEPTH].uid_seen) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_CHG_UID, KIND_CHG_LVL: begin
                n_ok = w_chain[TABLE_DEPTH].uid_seen;
            end
            default: begin
            end
        endcase
    end

    // Hold state, count and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_apply) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_ok        <= n_ok;
                        r_out_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the request beat with normalized UIDs
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op.kind    <= i_req.kind;
            r_op.key     <= mask_uid(i_req.key_low, i_req.key_high, i_req.key_len);
            r_op.new_key <= mask_uid(i_req.new_key_low, i_req.new_key_high,
                                     i_req.new_key_len);
            r_op.level   <= i_req.level;
        end
    end

    // Drive the response channel
    assign w_cnt_ext         = {{COUNT_OUT_W{1'b0}}, r_out_count};
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_ok;
    assign o_rsp.entry_count = w_cnt_ext[COUNT_OUT_W-1:0];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives table operations into access_tag_match_table and checks each reply
// against a local model of the tag table. A short directed run covers empty,
// saturated and over-long UIDs, junk above the UID length, level mismatch,
// both change operations, removal with shift-down and the unused kinds.
// After it come random phases that alternate between filling the table and
// draining it. Both sides idle at random, and the reply side stalls long
// once so that the block backs up into its request channel.
// ----------------------------------------------------------------------------
module testbench;
    import atmt_pkg::*;

    localparam int          TABLE_DEPTH       = TABLE_DEPTH_DEF;
    localparam int          POOL_SIZE         = 12;
    localparam int          STALL_LIMIT       = 1000;
    localparam int          TAIL_CYCLES       = 12;
    localparam int          HOLDOFF_CYCLES    = 120;
    localparam int          HOLDOFF_AT_BEAT   = 150;
    localparam int          QUIET_FIRST_BEAT  = 400;
    localparam int          QUIET_LAST_BEAT   = 600;
    localparam logic [2:0]  KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  KIND_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic       ok;
        logic [4:0] count;
    } t_verdict;

    logic clk;
    logic rst_n;

    atmt_req_if req_bus ();
    atmt_rsp_if rsp_bus ();

    access_tag_match_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Local copy of the table
    t_entry     tag_table [TABLE_DEPTH];
    int         tag_count;

    // Stimulus and scoreboard storage
    t_op        pending_ops[$];
    t_verdict   awaited_replies[$];
    t_uid       uid_pool [POOL_SIZE];
    logic [7:0] level_pool [POOL_SIZE];
    t_op        offered_op;
    int         sent_beats;
    int         taken_beats;
    int         hold_left;
    bit         holdoff_done;
    int         errors;
    int         quiet_cycles;

    // Keep the bytes below len, clear the rest
    function automatic logic [79:0] byte_mask(input logic [3:0] len);
        logic [80:0] m;
        m = (81'd1 << (8 * len)) - 81'd1;
        return m[79:0];
    endfunction

    // Saturate the length and clear the bytes above it
    function automatic t_uid trim_uid(input t_uid raw);
        t_uid        u;
        logic [79:0] bits;
        u.len = (raw.len > 4'(UID_MAX_BYTES)) ? 4'(UID_MAX_BYTES) : raw.len;
        bits  = {raw.hi, raw.lo} & byte_mask(u.len);
        u.lo  = bits[63:0];
        u.hi  = bits[79:64];
        return u;
    endfunction

    // Apply one operation to the local table and return the reply it earns
    function automatic t_verdict table_apply(input t_op op);
        t_uid     k;
        t_uid     nk;
        t_verdict v;
        int       hit;
        k   = trim_uid(op.key);
        nk  = trim_uid(op.new_key);
        hit = -1;
        v.ok = 1'b0;
        for (int i = 0; i < tag_count; i++) begin
            if (hit < 0 && tag_table[i].uid == k) begin
                hit = i;
            end
        end
        case (op.kind)
            KIND_CHECK: begin
                for (int i = 0; i < tag_count; i++) begin
                    if (tag_table[i].uid == k && tag_table[i].level == op.level) begin
                        v.ok = 1'b1;
                    end
                end
            end
            KIND_ADD: begin
                if (tag_count < TABLE_DEPTH) begin
                    tag_table[tag_count].uid   = k;
                    tag_table[tag_count].level = op.level;
                    tag_count++;
                    v.ok = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i < tag_count - 1; i++) begin
                        tag_table[i] = tag_table[i + 1];
                    end
                    tag_count--;
                    v.ok = 1'b1;
                end
            end
            KIND_CHG_UID: begin
                if (hit >= 0) begin
                    tag_table[hit].uid = nk;
                    v.ok = 1'b1;
                end
            end
            KIND_CHG_LVL: begin
                if (hit >= 0) begin
                    tag_table[hit].level = op.level;
                    v.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        v.count = 5'(tag_count);
        return v;
    endfunction

    function automatic t_uid random_uid();
        t_uid u;
        u.lo  = {$urandom, $urandom};
        u.hi  = 16'($urandom);
        u.len = 4'($urandom_range(0, 15));
        return u;
    endfunction

    // Same UID as clean, with junk above its length and over-long lengths at times
    function automatic t_uid dress_uid(input t_uid clean);
        t_uid        raw;
        logic [79:0] junk;
        raw  = clean;
        junk = {16'($urandom), $urandom, $urandom};
        if ($urandom_range(0, 1) == 1) begin
            {raw.hi, raw.lo} = {clean.hi, clean.lo} | (junk & ~byte_mask(clean.len));
        end
        if (clean.len == 4'(UID_MAX_BYTES) && $urandom_range(0, 1) == 1) begin
            raw.len = 4'($urandom_range(UID_MAX_BYTES, 15));
        end
        return raw;
    endfunction

    function automatic t_op mk_op(input logic [2:0] kind, input t_uid key,
                                  input t_uid new_key, input logic [7:0] level);
        t_op op;
        op.kind    = kind;
        op.key     = key;
        op.new_key = new_key;
        op.level   = level;
        return op;
    endfunction

    // Mostly keys from a small pool so that lookups hit; some pure noise
    function automatic t_op gen_random_op(input int add_pct);
        t_op op;
        int  s;
        int  r;
        s = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 49) == 0) begin
            uid_pool[s]   = trim_uid(random_uid());
            level_pool[s] = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            op.kind = KIND_ADD;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                op.kind = KIND_CHECK;
            end else if (r < 62) begin
                op.kind = KIND_REMOVE;
            end else if (r < 78) begin
                op.kind = KIND_CHG_UID;
            end else if (r < 96) begin
                op.kind = KIND_CHG_LVL;
            end else begin
                op.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            end
        end
        op.key     = ($urandom_range(0, 99) < 85) ? dress_uid(uid_pool[s]) : random_uid();
        op.new_key = ($urandom_range(0, 99) < 70) ?
                     dress_uid(uid_pool[$urandom_range(0, POOL_SIZE - 1)]) : random_uid();
        op.level   = ($urandom_range(0, 99) < 65) ? level_pool[s] : 8'($urandom);
        return op;
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset and known input levels from time zero
    initial begin
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.kind         = KIND_CHECK;
        req_bus.key_low      = '0;
        req_bus.key_high     = '0;
        req_bus.key_len      = '0;
        req_bus.new_key_low  = '0;
        req_bus.new_key_high = '0;
        req_bus.new_key_len  = '0;
        req_bus.level        = '0;
        rsp_bus.ready        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus, then the end of the run
    initial begin
        t_uid ua_raw;
        t_uid ua;
        t_uid ub_long;
        t_uid ub;
        t_uid uc_junk;
        t_uid uc;
        t_uid ud;
        t_uid ud_wide;
        t_uid ue_raw;
        t_uid ue;
        t_uid uz;
        tag_count = 0;
        errors    = 0;
        for (int s = 0; s < POOL_SIZE; s++) begin
            uid_pool[s]   = trim_uid(random_uid());
            level_pool[s] = 8'($urandom);
        end

        ua_raw  = '{lo: 64'hA5A5_A5A5_DEAD_BEEF, hi: 16'h5A5A, len: 4'd4};
        ua      = '{lo: 64'h0000_0000_DEAD_BEEF, hi: 16'h0000, len: 4'd4};
        ub_long = '{lo: '1, hi: '1, len: 4'd15};
        ub      = '{lo: '1, hi: '1, len: 4'd10};
        uc_junk = '{lo: '1, hi: 16'h1234, len: 4'd0};
        uc      = '{lo: '0, hi: '0, len: 4'd0};
        ud      = '{lo: 64'h8877_6655_4433_2211, hi: 16'hFF99, len: 4'd9};
        ud_wide = '{lo: 64'h8877_6655_4433_2211, hi: 16'hFF99, len: 4'd10};
        ue_raw  = '{lo: 64'hFFFF_FFFF_FF12_3456, hi: 16'hC3C3, len: 4'd3};
        ue      = '{lo: 64'h0000_0000_0012_3456, hi: 16'h0000, len: 4'd3};
        uz      = '{lo: 64'h42, hi: 16'h0000, len: 4'd1};

        // Directed: empty table, saturation, junk bytes, empty UID, both changes
        pending_ops.push_back(mk_op(KIND_CHECK,   ua,      uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_REMOVE,  ua,      uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_ADD,     ua_raw,  uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_ADD,     ub_long, uz,      8'hFF));
        pending_ops.push_back(mk_op(KIND_ADD,     uc_junk, uz,      8'h00));
        pending_ops.push_back(mk_op(KIND_ADD,     ud,      uz,      8'h80));
        pending_ops.push_back(mk_op(KIND_CHECK,   ua,      uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_CHECK,   ua,      uz,      8'd6));
        pending_ops.push_back(mk_op(KIND_CHECK,   '{lo: ua.lo, hi: ua.hi, len: 4'd5}, uz, 8'd5));
        pending_ops.push_back(mk_op(KIND_CHECK,   ub,      uz,      8'hFF));
        pending_ops.push_back(mk_op(KIND_CHECK,   uc,      uz,      8'h00));
        pending_ops.push_back(mk_op(KIND_CHECK,   ud_wide, uz,      8'h80));
        pending_ops.push_back(mk_op(KIND_CHG_LVL, ua,      uz,      8'd6));
        pending_ops.push_back(mk_op(KIND_CHECK,   ua_raw,  uz,      8'd6));
        pending_ops.push_back(mk_op(KIND_CHG_UID, ub,      ue_raw,  8'h00));
        pending_ops.push_back(mk_op(KIND_CHECK,   ue,      uz,      8'hFF));
        pending_ops.push_back(mk_op(KIND_CHG_UID, uz,      ua,      8'h00));
        pending_ops.push_back(mk_op(KIND_CHG_LVL, uz,      uz,      8'h11));
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
            pending_ops.push_back(mk_op(3'(k), ua, ub, 8'd5));
        end
        pending_ops.push_back(mk_op(KIND_ADD,     ua,      uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_REMOVE,  ua_raw,  uz,      8'd0));
        pending_ops.push_back(mk_op(KIND_CHECK,   ua,      uz,      8'd5));
        pending_ops.push_back(mk_op(KIND_REMOVE,  uc_junk, uz,      8'd0));
        pending_ops.push_back(mk_op(KIND_CHECK,   ud,      uz,      8'h80));

        // Random: alternate fill-heavy and drain-heavy phases
        for (int blk = 0; blk < 10; blk++) begin
            int add_pct;
            add_pct = (blk % 2 == 0) ? $urandom_range(55, 75) : $urandom_range(5, 20);
            repeat (100) pending_ops.push_back(gen_random_op(add_pct));
        end

        // Wait for every beat to be sent and answered, then let the pipe drain
        @(posedge clk);
        while (pending_ops.size() != 0 || req_bus.valid || awaited_replies.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Request driver: predict on each accepted beat, then offer the next
    always @(posedge clk) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
            sent_beats    <= 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                awaited_replies.push_back(table_apply(offered_op));
                sent_beats <= sent_beats + 1;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_ops.size() != 0 &&
                    ((sent_beats >= QUIET_FIRST_BEAT && sent_beats < QUIET_LAST_BEAT) ||
                     $urandom_range(0, 99) >= 35)) begin
                    offered_op            = pending_ops.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.kind         <= offered_op.kind;
                    req_bus.key_low      <= offered_op.key.lo;
                    req_bus.key_high     <= offered_op.key.hi;
                    req_bus.key_len      <= offered_op.key.len;
                    req_bus.new_key_low  <= offered_op.new_key.lo;
                    req_bus.new_key_high <= offered_op.new_key.hi;
                    req_bus.new_key_len  <= offered_op.new_key.len;
                    req_bus.level        <= offered_op.level;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Reply side ready: random stalls, one long hold-off, one quiet stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            taken_beats   <= 0;
            hold_left     <= 0;
            holdoff_done  <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                taken_beats <= taken_beats + 1;
            end
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                rsp_bus.ready <= 1'b0;
            end else if (!holdoff_done && taken_beats >= HOLDOFF_AT_BEAT) begin
                hold_left     <= HOLDOFF_CYCLES;
                holdoff_done  <= 1'b1;
                rsp_bus.ready <= 1'b0;
            end else if (taken_beats >= QUIET_FIRST_BEAT && taken_beats < QUIET_LAST_BEAT) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // Reply monitor: compare each beat with the oldest prediction
    always @(posedge clk) begin
        t_verdict want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual ok=%0b count=%0d",
                         $time, rsp_bus.ok, rsp_bus.entry_count);
                errors++;
            end else begin
                want = awaited_replies.pop_front();
                if (rsp_bus.ok !== want.ok) begin
                    $display("%0t: ok mismatch, expected %0b, actual %0b",
                             $time, want.ok, rsp_bus.ok);
                    errors++;
                end
                if (rsp_bus.entry_count !== want.count) begin
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                             $time, want.count, rsp_bus.entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
